// ===== src/xcmf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcmf_pkg
// Types and codes shared by the framer modules: item and result words,
// register indexes, status codes and the internal result-run record.
// ---------------------------------------------------------------------------
package xcmf_pkg;

	localparam int RunMax = 6;

	// input item
	typedef struct packed {
		logic        mode;
		logic [7:0]  msg_type;
		logic [15:0] payload_length;
		logic [7:0]  data_byte;
	} in_t;

	// result word
	typedef struct packed {
		logic [7:0] tx_byte;
		logic [1:0] status;
		logic       last_of_run;
	} out_t;

	localparam logic MODE_HEADER  = 1'b0;
	localparam logic MODE_PAYLOAD = 1'b1;

	localparam logic [1:0] ST_FRAME  = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_STRAY  = 2'd2;

	localparam logic [1:0] CFG_START = 2'd0;
	localparam logic [1:0] CFG_STOP  = 2'd1;
	localparam logic [1:0] CFG_LIMIT = 2'd2;

	typedef struct packed {
		logic [7:0]  start_marker;
		logic [7:0]  stop_marker;
		logic [15:0] payload_limit;
	} cfg_t;

	// words caused by one item; entry 0 goes out first
	typedef struct packed {
		logic [RunMax-1:0][7:0] bytes;
		logic [2:0]             cnt;
		logic [1:0]             status;
	} run_t;

endpackage

// ===== src/xcmf_cfg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcmf_cfg
// Configuration register file: start marker, stop marker, payload limit.
// ---------------------------------------------------------------------------
module xcmf_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output xcmf_pkg::cfg_t      cfg
);
	import xcmf_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker  <= 8'd2;
			cfg_q.stop_marker   <= 8'd3;
			cfg_q.payload_limit <= 16'd256;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_START: cfg_q.start_marker  <= cfg_data[7:0];
				CFG_STOP:  cfg_q.stop_marker   <= cfg_data[7:0];
				CFG_LIMIT: cfg_q.payload_limit <= cfg_data;
				default:   ; // writes beyond the map are dropped
			endcase
		end
	end

endmodule

// ===== src/xcmf_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcmf_core
// Frame state and the single-pass logic that turns one item into its run of
// output words.
// ---------------------------------------------------------------------------
module xcmf_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  xcmf_pkg::in_t     item,
	input  xcmf_pkg::cfg_t    cfg,
	output xcmf_pkg::run_t    run
);
	import xcmf_pkg::*;

	logic        open_q,  open_d;
	logic [15:0] rem_q,   rem_d;
	logic [7:0]  csum_q,  csum_d;

	logic [7:0]  lo, hi, hdr_csum, pay_csum;
	logic [15:0] rem_dec;

	always_comb begin
		lo       = item.payload_length[7:0];
		hi       = item.payload_length[15:8];
		hdr_csum = lo ^ hi ^ item.msg_type;
		pay_csum = csum_q ^ item.data_byte;
		rem_dec  = rem_q - 16'd1;

		run    = '0;
		open_d = open_q;
		rem_d  = rem_q;
		csum_d = csum_q;

		if (item.mode == MODE_HEADER) begin
			// a header always abandons whatever frame was open
			open_d = 1'b0;
			rem_d  = '0;
			csum_d = '0;
			if (item.payload_length > cfg.payload_limit) begin
				run.cnt    = 3'd1;
				run.status = ST_REJECT;
			end else begin
				run.bytes[0] = cfg.start_marker;
				run.bytes[1] = lo;
				run.bytes[2] = hi;
				run.bytes[3] = item.msg_type;
				run.status   = ST_FRAME;
				if (item.payload_length == '0) begin
					run.bytes[4] = hdr_csum;
					run.bytes[5] = cfg.stop_marker;
					run.cnt      = 3'd6;
				end else begin
					run.cnt = 3'd4;
					open_d  = 1'b1;
					rem_d   = item.payload_length;
					csum_d  = hdr_csum;
				end
			end
		end else if (!open_q || rem_q == '0) begin
			open_d     = 1'b0;
			rem_d      = '0;
			run.cnt    = 3'd1;
			run.status = ST_STRAY;
		end else begin
			run.bytes[0] = item.data_byte;
			run.status   = ST_FRAME;
			if (rem_dec == '0) begin
				run.bytes[1] = pay_csum;
				run.bytes[2] = cfg.stop_marker;
				run.cnt      = 3'd3;
				open_d       = 1'b0;
				rem_d        = '0;
				csum_d       = '0;
			end else begin
				run.cnt = 3'd1;
				rem_d   = rem_dec;
				csum_d  = pay_csum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			rem_q  <= '0;
			csum_q <= '0;
		end else if (load) begin
			open_q <= open_d;
			rem_q  <= rem_d;
			csum_q <= csum_d;
		end
	end

endmodule

// ===== src/xcmf_ser.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcmf_ser
// Result register: holds one run of words and shifts it out one word per
// handshake. Takes a new run in the cycle its last word leaves.
// ---------------------------------------------------------------------------
module xcmf_ser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  xcmf_pkg::run_t    run,
	output logic              busy,
	output logic              done,
	output logic              out_valid,
	input  logic              out_stall,
	output xcmf_pkg::out_t    result
);
	import xcmf_pkg::*;

	logic                   valid_q;
	logic [2:0]             cnt_q;
	logic [RunMax-1:0][7:0] bytes_q;
	logic [1:0]             status_q;
	logic                   take;

	assign take      = valid_q && !out_stall;
	assign busy      = valid_q;
	assign done      = take && cnt_q == 3'd1;
	assign out_valid = valid_q;

	assign result.tx_byte     = bytes_q[0];
	assign result.status      = status_q;
	assign result.last_of_run = (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q   <= run.cnt;
		end else if (take) begin
			valid_q <= (cnt_q != 3'd1);
			cnt_q   <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q  <= run.bytes;
			status_q <= run.status;
		end else if (take) begin
			bytes_q <= {8'h00, bytes_q[RunMax-1:1]};
		end
	end

endmodule

// ===== src/xor_checksum_message_framer_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xor_checksum_message_framer_top
// Start/stop byte framer with XOR checksum over length, type and payload.
// ---------------------------------------------------------------------------
// Each accepted item produces a run of 1 to 6 output words (header: 1, 4 or
// 6; payload byte: 1 or 3). The first word of a run is valid the cycle after
// the item is accepted. A payload byte inside a frame makes a one-word run, so
// a payload streams at one byte per cycle while the output is not stalled; an
// item with a longer run stalls the input until its last word is taken, also
// through any output stall. The limit is the single result register, which
// shifts out one word per handshake and takes the next item in the same
// cycle its last word leaves. Configuration writes are always ready and
// must be made while no run is in flight.
module xor_checksum_message_framer_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  xcmf_pkg::in_t     item,
	output logic              out_valid,
	input  logic              out_stall,
	output xcmf_pkg::out_t    result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import xcmf_pkg::*;

	cfg_t cfg;
	run_t run;
	logic busy, done, load;

	assign in_stall = busy && !done;
	assign load     = in_valid && !in_stall;

	xcmf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	xcmf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.item   (item),
		.cfg    (cfg),
		.run    (run)
	);

	xcmf_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.run       (run),
		.busy      (busy),
		.done      (done),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

endmodule

// ===== src/xcmf_chk.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcmf_chk
// Port-level checks for the framer, bound to the top level.
// ---------------------------------------------------------------------------
module xcmf_chk (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              out_valid,
	input  logic              out_stall,
	input  xcmf_pkg::out_t    result
);
	import xcmf_pkg::*;

	// a pending word stays up while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// an accepted item always shows its first word next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted item produced no word");

	// input is held off only by a run still in the result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no word pending");

	// error words are single-word runs with a zero byte
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result.status != ST_FRAME |-> result.last_of_run && result.tx_byte == 8'h00)
		else $error("error word not a lone zero word");

endmodule

bind xor_checksum_message_framer_top xcmf_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.result    (result)
);

// ===== tb/xcmf_frame_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcmf_frame_checker
// Watches the item, result and register-write channels of the framer. It
// keeps its own copy of the frame state and the marker/limit registers,
// computes the words each accepted item produces, and compares every
// accepted result word with the oldest word still due.
// ---------------------------------------------------------------------------
module xcmf_frame_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  xcmf_pkg::in_t  item,
	input  logic           out_valid,
	input  logic           out_stall,
	input  xcmf_pkg::out_t result,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	output int unsigned    fails,
	output int unsigned    outstanding
);
	import xcmf_pkg::*;

	localparam int unsigned ReportMax = 10;

	logic [7:0]  start_byte;
	logic [7:0]  stop_byte;
	logic [15:0] len_limit;
	logic        in_frame;
	logic [15:0] bytes_left;
	logic [7:0]  chk_accum;

	out_t        framed_q[$];
	int unsigned err_cnt;

	initial begin
		err_cnt = 0;
	end

	task automatic queue_byte(input logic [7:0] b, input logic [1:0] st);
		out_t w;
		w.tx_byte = b;
		w.status = st;
		w.last_of_run = 1'b0;
		framed_q.push_back(w);
	endtask

	task automatic queue_tail();
		queue_byte(chk_accum, ST_FRAME);
		queue_byte(stop_byte, ST_FRAME);
		in_frame = 1'b0;
		bytes_left = '0;
		chk_accum = '0;
	endtask

	// words produced by one accepted item, appended in send order
	task automatic frame_item(input in_t w);
		out_t tail_word;
		if (w.mode == MODE_HEADER) begin
			in_frame = 1'b0;
			bytes_left = '0;
			chk_accum = '0;
			if (w.payload_length > len_limit) begin
				queue_byte(8'h00, ST_REJECT);
			end else begin
				queue_byte(start_byte, ST_FRAME);
				queue_byte(w.payload_length[7:0], ST_FRAME);
				queue_byte(w.payload_length[15:8], ST_FRAME);
				queue_byte(w.msg_type, ST_FRAME);
				chk_accum = w.payload_length[7:0] ^ w.payload_length[15:8] ^ w.msg_type;
				if (w.payload_length == 16'd0) begin
					queue_tail();
				end else begin
					in_frame = 1'b1;
					bytes_left = w.payload_length;
				end
			end
		end else if (!in_frame || bytes_left == 16'd0) begin
			in_frame = 1'b0;
			bytes_left = '0;
			queue_byte(8'h00, ST_STRAY);
		end else begin
			queue_byte(w.data_byte, ST_FRAME);
			chk_accum = chk_accum ^ w.data_byte;
			bytes_left = bytes_left - 16'd1;
			if (bytes_left == 16'd0)
				queue_tail();
		end
		tail_word = framed_q[$];
		framed_q.pop_back();
		tail_word.last_of_run = 1'b1;
		framed_q.push_back(tail_word);
	endtask

	task automatic note_error(input out_t want, input out_t got, input bit none_due);
		err_cnt++;
		if (err_cnt <= ReportMax) begin
			if (none_due)
				$display("%0t: unexpected word tx=%02h st=%0d last=%0b", $realtime,
					got.tx_byte, got.status, got.last_of_run);
			else
				$display("%0t: expected tx=%02h st=%0d last=%0b, got tx=%02h st=%0d last=%0b",
					$realtime, want.tx_byte, want.status, want.last_of_run,
					got.tx_byte, got.status, got.last_of_run);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			start_byte = 8'd2;
			stop_byte = 8'd3;
			len_limit = 16'd256;
			in_frame = 1'b0;
			bytes_left = '0;
			chk_accum = '0;
			framed_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START: start_byte = cfg_data[7:0];
					CFG_STOP:  stop_byte = cfg_data[7:0];
					CFG_LIMIT: len_limit = cfg_data;
					default: ;
				endcase
			end
			// compare before queuing: a word leaving now predates this edge's item
			if (out_valid && !out_stall) begin
				if (framed_q.size() == 0) begin
					want = '0;
					note_error(want, result, 1'b1);
				end else begin
					want = framed_q.pop_front();
					if (result.tx_byte !== want.tx_byte || result.status !== want.status ||
					    result.last_of_run !== want.last_of_run)
						note_error(want, result, 1'b0);
				end
			end
			if (in_valid && !in_stall)
				frame_item(item);
		end
		outstanding <= framed_q.size();
		fails <= err_cnt;
	end

endmodule

// ===== tb/tb_xor_checksum_message_framer_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_xor_checksum_message_framer_top
// Drives the framer with directed and random item streams under several
// marker/limit settings, with random gaps on both channels; the checker
// beside the block predicts and compares every result word.
// ---------------------------------------------------------------------------
module tb_xor_checksum_message_framer_top;
	import xcmf_pkg::*;

	localparam int unsigned StallLimit = 5000;
	localparam int unsigned PhaseItems = 85;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_t         item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_t        result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_START;
	logic [15:0] cfg_data = '0;

	int unsigned fails;
	int unsigned outstanding;
	int unsigned sent = 0;
	int unsigned quiet_cycles = 0;
	bit          calm = 1'b0;
	logic [15:0] cur_limit = 16'd256;

	xor_checksum_message_framer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.item      (item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	xcmf_frame_checker u_frame_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.item        (item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fails       (fails),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 37);
	end

	// no handshake on any channel for too long ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == StallLimit) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_item(input in_t w);
		calm = (sent >= 200 && sent < 290);
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	function automatic in_t noise_word();
		in_t w;
		w.mode = 1'($urandom_range(1));
		w.msg_type = 8'($urandom);
		w.payload_length = 16'($urandom);
		w.data_byte = 8'($urandom);
		return w;
	endfunction

	task automatic send_header(input logic [7:0] kind, input logic [15:0] len);
		in_t w;
		w = noise_word();
		w.mode = MODE_HEADER;
		w.msg_type = kind;
		w.payload_length = len;
		send_item(w);
	endtask

	task automatic send_payload(input logic [7:0] b);
		in_t w;
		w = noise_word();
		w.mode = MODE_PAYLOAD;
		w.data_byte = b;
		send_item(w);
	endtask

	// every item yields at least one word, so an empty queue means idle
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_regs(input logic [7:0] sb, input logic [7:0] eb, input logic [15:0] lim);
		drain();
		// upper data bits are junk for the 8-bit markers
		write_reg(CFG_START, {8'($urandom), sb});
		write_reg(CFG_STOP, {8'($urandom), eb});
		write_reg(CFG_LIMIT, lim);
		cfg_valid <= 1'b0;
		cur_limit = lim;
	endtask

	function automatic logic [15:0] pick_len();
		int unsigned r;
		int unsigned cap;
		r = $urandom_range(99);
		if (r < 2 && cur_limit >= 300)
			return 16'($urandom_range(300, 64));
		if (r < 8 && cur_limit <= 64)
			return cur_limit;
		if (r < 16 && cur_limit != 16'hFFFF)
			return 16'(cur_limit + 1 + $urandom_range(0, 32'hFFFF - cur_limit - 1));
		cap = (cur_limit < 10) ? cur_limit : 10;
		return 16'($urandom_range(cap, 0));
	endfunction

	task automatic random_phase(input int unsigned quota);
		int unsigned first;
		int unsigned r;
		int unsigned n;
		logic [15:0] len;
		first = sent;
		while (sent - first < quota) begin
			r = $urandom_range(99);
			if (r < 6) begin
				send_payload(8'($urandom));
			end else if (r < 12) begin
				send_header(8'($urandom), 16'($urandom));
			end else begin
				len = pick_len();
				send_header(8'($urandom), len);
				if (len <= cur_limit && len != 0) begin
					n = 32'(len);
					r = $urandom_range(99);
					if (r < 10)
						n = $urandom_range(len - 1, 0);
					else if (r < 15)
						n = 32'(len) + 1;
					repeat (n) send_payload(8'($urandom));
				end
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values
		send_payload(8'hFF);
		send_header(8'h00, 16'd0);
		send_header(8'hFF, 16'd0);
		send_header(8'hA5, 16'hFFFF);
		send_header(8'h3C, 16'd257);
		send_header(8'h5A, 16'd2);
		send_payload(8'h00);
		send_payload(8'hFF);
		send_payload(8'h00);
		send_header(8'h81, 16'd3);
		send_payload(8'h12);
		send_header(8'h42, 16'd1);
		send_payload(8'hC3);
		send_header(8'h7F, 16'd256);
		send_payload(8'h55);
		send_payload(8'hAA);
		send_header(8'h11, 16'd300);
		send_payload(8'h01);
		send_header(8'h01, 16'h00FF);
		send_payload(8'h80);
		send_header(8'hE7, 16'd1);
		send_payload(8'h7F);

		set_regs(8'h00, 8'hFF, 16'd0);
		random_phase(PhaseItems);
		set_regs(8'hFF, 8'h00, 16'hFFFF);
		random_phase(PhaseItems);
		set_regs(8'h7E, 8'h7D, 16'd5);
		random_phase(PhaseItems);
		set_regs(8'($urandom), 8'($urandom), 16'($urandom_range(40, 1)));
		random_phase(PhaseItems);
		set_regs(8'h02, 8'h03, 16'd256);
		random_phase(PhaseItems);

		drain();
		repeat (20) @(posedge clk);
		if (fails == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
